// ===== sv/lsfa_pkg.sv =====
// shared types and codes for the led strip frame animator
package lsfa_pkg;

   typedef enum logic [1:0] {
      ACT_FILL    = 2'd0,
      ACT_TICK    = 2'd1,
      ACT_REFRESH = 2'd2,
      ACT_OFF     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_EMIT,
      ST_DRAIN
   } state_type;

   typedef enum logic [1:0] {
      CSR_FLOW_INTERVAL    = 2'd0,
      CSR_ANIMATION_ENABLE = 2'd1,
      CSR_ANIMATION_MODE   = 2'd2
   } csr_index_type;

   localparam logic [7:0] MODE_ROT_UP   = 8'd1;
   localparam logic [7:0] MODE_ROT_DOWN = 8'd2;
   localparam logic [7:0] MODE_SPLIT    = 8'd3;
   localparam logic [7:0] MODE_PAIRS    = 8'd4;

   localparam logic [7:0] INTERVAL_RESET = 8'd10;
   localparam logic [7:0] MODE_RESET     = 8'd1;

   localparam int PIXEL_W = 24;

endpackage

// ===== sv/rgb_led_strip_frame_animator_top.sv =====
// frame buffer and animator for an addressable led strip, top level
//
// The frame sits in two pixel memories used as ping-pong banks; one is the
// live frame. A fill item writes its range into the live bank, one pixel per
// cycle. A refresh or off item streams NUM_LEDS words, pixel 0 first, one
// memory read per word, and stalls while the result queue is full. An
// animation step reads the live bank in the moved order, writes each word
// into the other bank while sending it, and swaps banks at the end, at the
// same cost as a refresh. A tick that does not step sends no words. The
// frame reads as dark after reset through per-pixel valid bits, so there is
// no clearing pass. The result side has a two-word queue, so a new item may
// be taken while words of the previous transfer still wait.
module rgb_led_strip_frame_animator_top #(
   parameter int NUM_LEDS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // first_led, last_led, red, green, blue
   input  logic [1:0]  req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // wire_word
   output logic        rsp_tlast,   // last_word
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int AW = $clog2(NUM_LEDS);
   localparam logic [AW-1:0] LAST_IDX = AW'(NUM_LEDS - 1);
   localparam logic [AW-1:0] HALF_IDX = AW'(NUM_LEDS / 2);
   localparam logic [7:0] NUM_LEDS8 = 8'(NUM_LEDS);
   localparam int PW = lsfa_pkg::PIXEL_W;

   lsfa_pkg::state_type state_ff, state_in;

   logic [7:0]    interval_ff, interval_in;
   logic          enable_ff, enable_in;
   logic [7:0]    mode_ff, mode_in;
   logic [7:0]    tick_ff, tick_in;
   logic          act_ff, act_in;
   logic [NUM_LEDS-1:0] valid_ff [2];
   logic [NUM_LEDS-1:0] valid_in [2];
   logic [7:0]    fill_idx_ff, fill_idx_in;
   logic [7:0]    fill_end_ff, fill_end_in;
   logic [PW-1:0] fill_word_ff, fill_word_in;
   logic [AW-1:0] k_ff, k_in;
   logic          step_ff, step_in;
   logic          dark_ff, dark_in;
   logic          inflight_ff, inflight_in;
   logic [AW-1:0] k_d_ff, k_d_in;
   logic          last_d_ff, last_d_in;
   logic          vld_d_ff, vld_d_in;
   logic [PW-1:0] q_word_ff [2];
   logic          q_last_ff [2];
   logic          wptr_ff, wptr_in;
   logic          rptr_ff, rptr_in;
   logic [1:0]    cnt_ff, cnt_in;

   logic          req_accept;
   logic          pop;
   logic          push;
   logic          issue;
   logic          fill_we;
   logic          step_wr;
   logic [AW-1:0] src;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic [PW-1:0] wr_data;
   logic [PW-1:0] rd_q0, rd_q1;
   logic [PW-1:0] arr_word;
   logic [PW-1:0] emit_word;
   logic [7:0]    lo, hi, hi_c, tick_inc;
   lsfa_pkg::action_type action;

   assign action     = lsfa_pkg::action_type'(req_tuser);
   assign req_tready = (state_ff == lsfa_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign push       = inflight_ff;
   assign rsp_tdata  = q_word_ff[rptr_ff];
   assign rsp_tlast  = q_last_ff[rptr_ff];

   assign fill_we  = (state_ff == lsfa_pkg::ST_FILL) && (fill_idx_ff <= fill_end_ff);
   assign step_wr  = inflight_ff && step_ff;
   assign arr_word = vld_d_ff ? (act_ff ? rd_q1 : rd_q0) : '0;
   assign emit_word = dark_ff ? '0 : arr_word;
   assign wr_addr  = fill_we ? fill_idx_ff[AW-1:0] : k_d_ff;
   assign wr_data  = fill_we ? fill_word_ff : arr_word;

   // source pixel of output position k for an animation step
   always_comb begin
      src = k_ff;
      case (mode_ff)
         lsfa_pkg::MODE_ROT_UP: begin
            src = (k_ff == '0) ? LAST_IDX : k_ff - AW'(1);
         end
         lsfa_pkg::MODE_ROT_DOWN: begin
            src = (k_ff == LAST_IDX) ? '0 : k_ff + AW'(1);
         end
         lsfa_pkg::MODE_SPLIT: begin
            if (k_ff < HALF_IDX) begin
               src = (k_ff == '0) ? HALF_IDX - AW'(1) : k_ff - AW'(1);
            end else begin
               src = (k_ff == LAST_IDX) ? HALF_IDX : k_ff + AW'(1);
            end
         end
         lsfa_pkg::MODE_PAIRS: begin
            src = (!k_ff[0] && (k_ff == LAST_IDX)) ? k_ff : (k_ff ^ AW'(1));
         end
         default: begin
            src = k_ff;
         end
      endcase
      rd_addr = step_ff ? src : k_ff;
   end

   // configuration
   always_comb begin
      interval_in = interval_ff;
      enable_in   = enable_ff;
      mode_in     = mode_ff;
      if (csr_we) begin
         case (lsfa_pkg::csr_index_type'(csr_index))
            lsfa_pkg::CSR_FLOW_INTERVAL:    interval_in = csr_wdata;
            lsfa_pkg::CSR_ANIMATION_ENABLE: enable_in   = csr_wdata[0];
            lsfa_pkg::CSR_ANIMATION_MODE:   mode_in     = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      act_in       = act_ff;
      valid_in     = valid_ff;
      fill_idx_in  = fill_idx_ff;
      fill_end_in  = fill_end_ff;
      fill_word_in = fill_word_ff;
      k_in         = k_ff;
      step_in      = step_ff;
      dark_in      = dark_ff;
      inflight_in  = 1'b0;
      k_d_in       = k_d_ff;
      last_d_in    = last_d_ff;
      vld_d_in     = vld_d_ff;
      issue        = 1'b0;
      lo           = (req_tdata[7:0] < req_tdata[15:8]) ? req_tdata[7:0] : req_tdata[15:8];
      hi           = (req_tdata[7:0] < req_tdata[15:8]) ? req_tdata[15:8] : req_tdata[7:0];
      hi_c         = (hi > NUM_LEDS8) ? NUM_LEDS8 : hi;
      tick_inc     = tick_ff + 8'd1;

      case (state_ff)
         lsfa_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (action)
                  lsfa_pkg::ACT_FILL: begin
                     fill_word_in = {req_tdata[39:32], req_tdata[23:16], req_tdata[31:24]};
                     fill_idx_in  = lo - 8'd1;
                     fill_end_in  = hi_c - 8'd1;
                     if (lo != 8'd0) begin
                        state_in = lsfa_pkg::ST_FILL;
                     end
                  end
                  lsfa_pkg::ACT_TICK: begin
                     if (enable_ff) begin
                        if (tick_inc < interval_ff) begin
                           tick_in = tick_inc;
                        end else begin
                           tick_in  = 8'd0;
                           step_in  = 1'b1;
                           dark_in  = 1'b0;
                           k_in     = '0;
                           state_in = lsfa_pkg::ST_EMIT;
                        end
                     end
                  end
                  lsfa_pkg::ACT_REFRESH: begin
                     step_in  = 1'b0;
                     dark_in  = 1'b0;
                     k_in     = '0;
                     state_in = lsfa_pkg::ST_EMIT;
                  end
                  lsfa_pkg::ACT_OFF: begin
                     step_in  = 1'b0;
                     dark_in  = 1'b1;
                     k_in     = '0;
                     state_in = lsfa_pkg::ST_EMIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         lsfa_pkg::ST_FILL: begin
            if (fill_we) begin
               valid_in[act_ff][fill_idx_ff[AW-1:0]] = 1'b1;
               fill_idx_in = fill_idx_ff + 8'd1;
            end else begin
               state_in = lsfa_pkg::ST_IDLE;
            end
         end
         lsfa_pkg::ST_EMIT: begin
            issue = ({1'b0, cnt_ff} + {2'b0, inflight_ff}) < (3'd2 + {2'b0, pop});
            if (issue) begin
               inflight_in = 1'b1;
               k_d_in      = k_ff;
               last_d_in   = (k_ff == LAST_IDX);
               vld_d_in    = valid_ff[act_ff][rd_addr];
               if (k_ff == LAST_IDX) begin
                  state_in = lsfa_pkg::ST_DRAIN;
               end else begin
                  k_in = k_ff + AW'(1);
               end
            end
         end
         lsfa_pkg::ST_DRAIN: begin
            if (!inflight_ff) begin
               if (step_ff) begin
                  act_in = ~act_ff;
               end
               state_in = lsfa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lsfa_pkg::ST_IDLE;
         end
      endcase

      if (step_wr) begin
         valid_in[~act_ff][k_d_ff] = 1'b1;
      end
   end

   // result queue
   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lsfa_pkg::ST_IDLE;
         interval_ff <= lsfa_pkg::INTERVAL_RESET;
         enable_ff   <= 1'b0;
         mode_ff     <= lsfa_pkg::MODE_RESET;
         tick_ff     <= 8'd0;
         act_ff      <= 1'b0;
         valid_ff[0] <= '0;
         valid_ff[1] <= '0;
         inflight_ff <= 1'b0;
         wptr_ff     <= 1'b0;
         rptr_ff     <= 1'b0;
         cnt_ff      <= 2'd0;
      end else begin
         state_ff    <= state_in;
         interval_ff <= interval_in;
         enable_ff   <= enable_in;
         mode_ff     <= mode_in;
         tick_ff     <= tick_in;
         act_ff      <= act_in;
         valid_ff    <= valid_in;
         inflight_ff <= inflight_in;
         wptr_ff     <= wptr_in;
         rptr_ff     <= rptr_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_idx_ff  <= fill_idx_in;
      fill_end_ff  <= fill_end_in;
      fill_word_ff <= fill_word_in;
      k_ff         <= k_in;
      step_ff      <= step_in;
      dark_ff      <= dark_in;
      k_d_ff       <= k_d_in;
      last_d_ff    <= last_d_in;
      vld_d_ff     <= vld_d_in;
      if (push) begin
         q_word_ff[wptr_ff] <= emit_word;
         q_last_ff[wptr_ff] <= last_d_ff;
      end
   end

   lsfa_ram #(
      .WIDTH (PW),
      .DEPTH (NUM_LEDS)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   ((fill_we && !act_ff) || (step_wr && act_ff)),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_q0)
   );

   lsfa_ram #(
      .WIDTH (PW),
      .DEPTH (NUM_LEDS)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   ((fill_we && act_ff) || (step_wr && !act_ff)),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_q1)
   );

`ifndef NO_ASSERTIONS
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff != 2'd2 || pop))
      else $error("result queue overflow");

   a_idle_no_read: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !inflight_ff)
      else $error("item accepted while a pixel read is in flight");

   a_bank_swap: assert property (@(posedge clock) disable iff (reset)
      (act_in != act_ff) |-> (state_ff == lsfa_pkg::ST_DRAIN && !inflight_ff && step_ff))
      else $error("bank swap outside the end of a step");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_we |-> (fill_idx_ff < NUM_LEDS8))
      else $error("fill write beyond the strip");

   a_last_word: assert property (@(posedge clock) disable iff (reset)
      (push && last_d_ff) |=> (state_ff == lsfa_pkg::ST_DRAIN && !inflight_ff))
      else $error("last word pushed before the transfer ended");
`endif

endmodule

// ===== sv/lsfa_ram.sv =====
// generic single write port, single read port ram with registered read
module lsfa_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== dv/testbench.sv =====
// testbench for the led strip frame animator: random fills, ticks, refreshes and off words
`timescale 1ns / 1ps

module testbench;
   import lsfa_pkg::*;

   localparam int LEDS = 64;
   localparam int SETTLE = 80;
   localparam int HOLD = 400;
   localparam int IDLE_LIMIT = 3000;

   class strip_scoreboard;
      logic [23:0] frame [LEDS];
      logic [7:0]  tick_total;
      logic [7:0]  interval;
      logic        enable;
      logic [7:0]  mode;
      logic [24:0] strip_words [$];
      int          errors;

      function new();
         foreach (frame[k]) frame[k] = '0;
         tick_total = '0;
         interval = INTERVAL_RESET;
         enable = 1'b0;
         mode = MODE_RESET;
         errors = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [7:0] value);
         case (idx)
            CSR_FLOW_INTERVAL:    interval = value;
            CSR_ANIMATION_ENABLE: enable = value[0];
            CSR_ANIMATION_MODE:   mode = value;
            default: ;
         endcase
      endfunction

      function void queue_strip(logic dark);
         for (int k = 0; k < LEDS; k++)
            strip_words.push_back({k == LEDS - 1, dark ? 24'd0 : frame[k]});
      endfunction

      function void note_request(action_type act, logic [7:0] lo_led, logic [7:0] hi_led,
                                 logic [7:0] red, logic [7:0] green, logic [7:0] blue);
         logic [23:0] moved [LEDS];
         int lo, hi, half;
         lo = int'(lo_led);
         hi = int'(hi_led);
         half = LEDS / 2;
         case (act)
            ACT_FILL: begin
               if (lo != 0 && hi != 0) begin
                  if (hi < lo) begin
                     hi = int'(lo_led);
                     lo = int'(hi_led);
                  end
                  if (hi > LEDS) hi = LEDS;
                  for (int p = lo; p <= hi; p++) frame[p - 1] = {blue, red, green};
               end
            end
            ACT_TICK: begin
               if (enable) begin
                  tick_total = tick_total + 8'd1;
                  if (tick_total >= interval) begin
                     tick_total = '0;
                     moved = frame;
                     case (mode)
                        MODE_ROT_UP:
                           for (int k = 0; k < LEDS; k++) moved[(k + 1) % LEDS] = frame[k];
                        MODE_ROT_DOWN:
                           for (int k = 0; k < LEDS; k++) moved[k] = frame[(k + 1) % LEDS];
                        MODE_SPLIT: begin
                           for (int k = 0; k < half; k++) moved[(k + 1) % half] = frame[k];
                           for (int k = half; k < LEDS; k++)
                              moved[k] = frame[(k == LEDS - 1) ? half : k + 1];
                        end
                        MODE_PAIRS:
                           for (int k = 0; k < LEDS; k++)
                              if ((k ^ 1) < LEDS) moved[k] = frame[k ^ 1];
                        default: ;
                     endcase
                     frame = moved;
                     queue_strip(1'b0);
                  end
               end
            end
            ACT_REFRESH: queue_strip(1'b0);
            default: queue_strip(1'b1);
         endcase
      endfunction

      function void check_word(logic [23:0] word, logic last_flag);
         logic [24:0] want;
         if (strip_words.size() == 0) begin
            $error("wire_word: none expected, actual %06h", word);
            errors++;
         end else begin
            want = strip_words.pop_front();
            if (word !== want[23:0]) begin
               $error("wire_word: expected %06h, actual %06h", want[23:0], word);
               errors++;
            end
            if (last_flag !== want[24]) begin
               $error("last_word: expected %0d, actual %0d", want[24], last_flag);
               errors++;
            end
         end
      endfunction

      function int pending();
         return strip_words.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // first_led, last_led, red, green, blue
   logic [1:0]  req_tuser;   // action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // wire_word
   logic        rsp_tlast;   // last_word
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [7:0]  csr_wdata;

   logic hold_rsp = 1'b0;
   logic calm = 1'b0;
   int   idle_cycles = 0;
   strip_scoreboard strip_sb = new();

   rgb_led_strip_frame_animator_top #(.NUM_LEDS(LEDS)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) strip_sb.check_word(rsp_tdata, rsp_tlast);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[rgb_led_strip_frame_animator_top] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : receiver
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD) @(negedge clock);
            hold_rsp = 1'b0;
         end
         if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic send(action_type act, logic [7:0] lo_led, logic [7:0] hi_led,
                       logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      @(negedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {blue, green, red, hi_led, lo_led};
      req_tuser <= act;
      do @(posedge clock); while (!req_tready);
      strip_sb.note_request(act, lo_led, hi_led, red, green, blue);
   endtask

   task automatic send_control(action_type act);
      send(act, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
           8'($urandom_range(0, 255)));
   endtask

   // stop offering, let every expected word arrive, then let the block go quiet
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (strip_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(logic [7:0] interval, logic enable, logic [7:0] mode);
      settle();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_FLOW_INTERVAL;
      csr_wdata <= interval;
      @(negedge clock);
      csr_index <= CSR_ANIMATION_ENABLE;
      csr_wdata <= {7'd0, enable};
      @(negedge clock);
      csr_index <= CSR_ANIMATION_MODE;
      csr_wdata <= mode;
      @(negedge clock);
      csr_we <= 1'b0;
      strip_sb.set_reg(CSR_FLOW_INTERVAL, interval);
      strip_sb.set_reg(CSR_ANIMATION_ENABLE, {7'd0, enable});
      strip_sb.set_reg(CSR_ANIMATION_MODE, mode);
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_led();
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1, 2:    return 8'($urandom_range(65, 255));
         default: return 8'($urandom_range(1, LEDS));
      endcase
   endfunction

   task automatic send_random();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         send(ACT_FILL, pick_led(), pick_led(), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      else if (pick < 75)
         send_control(ACT_TICK);
      else if (pick < 88)
         send_control(ACT_REFRESH);
      else
         send_control(ACT_OFF);
   endtask

   initial begin : stimulus
      logic [7:0] interval;
      logic       enable;
      logic [7:0] mode;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      send_control(ACT_REFRESH);
      send(ACT_FILL, 8'd1, 8'd255, 8'hff, 8'h00, 8'h80);
      send(ACT_FILL, 8'd0, 8'd5, 8'haa, 8'haa, 8'haa);
      send(ACT_FILL, 8'd5, 8'd0, 8'h55, 8'h55, 8'h55);
      send(ACT_FILL, 8'd40, 8'd20, 8'h01, 8'h7f, 8'hfe);
      send(ACT_FILL, 8'd255, 8'd255, 8'h33, 8'h44, 8'h55);
      send(ACT_FILL, 8'd64, 8'd64, 8'h00, 8'hff, 8'h00);
      send(ACT_FILL, 8'd1, 8'd1, 8'h00, 8'h00, 8'hff);
      send(ACT_FILL, 8'd100, 8'd60, 8'hc3, 8'h3c, 8'h99);
      send_control(ACT_REFRESH);
      send_control(ACT_OFF);
      send_control(ACT_TICK);
      send_control(ACT_REFRESH);
      configure(8'd1, 1'b1, MODE_ROT_UP);
      send_control(ACT_TICK);
      send_control(ACT_TICK);
      configure(8'd0, 1'b1, MODE_ROT_DOWN);
      send_control(ACT_TICK);
      configure(8'd0, 1'b1, MODE_SPLIT);
      send_control(ACT_TICK);
      configure(8'd0, 1'b1, MODE_PAIRS);
      send_control(ACT_TICK);
      configure(8'd0, 1'b1, 8'd0);
      send_control(ACT_TICK);
      configure(8'd0, 1'b1, 8'd255);
      send_control(ACT_TICK);
      // counter left above a lowered interval
      configure(8'd10, 1'b1, MODE_ROT_UP);
      repeat (5) send_control(ACT_TICK);
      configure(8'd3, 1'b1, MODE_ROT_UP);
      send_control(ACT_TICK);

      // random part in phases
      for (int p = 0; p < 5; p++) begin
         interval = (p == 0) ? 8'd255 : (p == 4) ? 8'd0 : 8'($urandom_range(0, 5));
         enable = (p == 1) ? 1'b0 : 1'b1;
         mode = (p == 2) ? 8'd255 : 8'($urandom_range(0, 5));
         configure(interval, enable, mode);
         for (int n = 0; n < 100; n++) begin
            if (p == 4 && n >= 40) calm = 1'b1;
            if (p == 2 && n == 10) hold_rsp = 1'b1;
            if (p == 2 && n >= 10 && n < 16)
               send_control(ACT_REFRESH);
            else
               send_random();
         end
      end

      settle();
      if (strip_sb.errors == 0)
         $display("[rgb_led_strip_frame_animator_top] OK");
      else
         $display("[rgb_led_strip_frame_animator_top] ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/lsfa_pkg.sv
sv/lsfa_ram.sv
sv/rgb_led_strip_frame_animator_top.sv
dv/testbench.sv
